@@ hdl/prq_pkg.sv @@
// prq_pkg: sizes, codes and transfer records shared by the packet ring queue
// modules. No dependencies.
`timescale 1ns / 1ps

package prq_pkg;

    localparam int SLOTS       = 8;
    localparam int MAX_LEN     = 256;
    localparam int BYTES_DEPTH = SLOTS * MAX_LEN;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int OFF_W  = $clog2(MAX_LEN + 1);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ADDR_W = $clog2(BYTES_DEPTH);
    localparam int CMP_W  = (OFF_W + 1 > 9) ? OFF_W + 1 : 9;

    // fixed field widths of the stream items
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 9;
    localparam int STAMP_W = 32;
    localparam int QCNT_W  = 4;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    // command queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_TRUNC = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        mode_t               mode;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_byte;
        logic [STAMP_W-1:0]  stamp;
    } item_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   wdata;
        status_t             status;
        logic                last;
        logic [LEN_W-1:0]    length;
        logic [STAMP_W-1:0]  stamp;
        logic [QCNT_W-1:0]   count;
    } cmd_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   out_byte;
        logic                out_last;
        logic [LEN_W-1:0]    out_length;
        logic [STAMP_W-1:0]  out_stamp;
        logic [QCNT_W-1:0]   queue_count;
    } result_t;

endpackage

@@ hdl/packet_ring_queue.sv @@
// packet_ring_queue: top level of the packet ring queue.
// Uses prq_pkg, prq_front, prq_cmd_queue and prq_back.
`timescale 1ns / 1ps

// Ring queue of SLOTS packet slots of up to MAX_LEN bytes each. Every input
// transfer (push byte, pop byte, clear) gives exactly one result transfer, in
// order. The block sustains one item per clock while the output is not
// stalled: each item needs at most one access of the single-port packet byte
// memory, and that port sets the rate. Commands pass through the command
// queue, the s1 stage and the result register. Indices, offsets, lengths and
// timestamps live in the front end; a two-entry command queue and the result
// register let the input and output sides stall independently. There is no
// clearing pass after reset: slot data is only read after it has been written.
module packet_ring_queue
    import prq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // data_byte[7:0], stamp[39:8]
    input  logic [1:0]          s_tuser,   // mode
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_byte[7:0], out_length[16:8],
                                           // out_stamp[48:17], queue_count[52:49]
    output logic [1:0]          m_tuser,   // status
    output logic                m_tlast
);

    item_t   item;
    cmd_t    front_cmd;
    cmd_t    back_cmd;
    result_t res;
    logic    front_valid;
    logic    front_ready;
    logic    back_valid;
    logic    back_ready;

    assign item.mode      = mode_t'(s_tuser);
    assign item.data_byte = s_tdata[BYTE_W-1:0];
    assign item.stamp     = s_tdata[BYTE_W+STAMP_W-1:BYTE_W];
    assign item.last_byte = s_tlast;

    prq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    prq_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    prq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {3'b000, res.queue_count, res.out_stamp, res.out_length, res.out_byte};
    assign m_tuser = res.status;
    assign m_tlast = res.out_last;

endmodule

@@ hdl/prq_ram.sv @@
// prq_ram: generic single-port RAM with registered read data.
// Standalone, no package.
`timescale 1ns / 1ps

module prq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/prq_front.sv @@
// prq_front: accepts items, keeps ring indices, offsets and slot headers,
// and turns each item into one command for the back end. Uses prq_pkg.
`timescale 1ns / 1ps

module prq_front
    import prq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t item,
    output logic  cmd_valid,
    input  logic  cmd_ready,
    output cmd_t  cmd
);

    logic [IDX_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [OFF_W-1:0]   wr_off_reg, wr_off_next;
    logic [OFF_W-1:0]   rd_off_reg, rd_off_next;
    logic               dropping_reg, dropping_next;

    logic [LEN_W-1:0]   length_reg [SLOTS];
    logic [STAMP_W-1:0] stamp_reg [SLOTS];

    logic               accept;
    logic               commit;
    logic [OFF_W-1:0]   wr_off_after;
    logic [LEN_W-1:0]   head_len;
    logic [CMP_W-1:0]   rd_off_inc;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;
    assign accept    = in_valid && cmd_ready;

    assign head_len   = length_reg[head_reg];
    assign rd_off_inc = CMP_W'(rd_off_reg) + CMP_W'(1);

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        wr_off_next   = wr_off_reg;
        rd_off_next   = rd_off_reg;
        dropping_next = dropping_reg;
        commit        = 1'b0;
        wr_off_after  = wr_off_reg;

        cmd        = '0;
        cmd.kind   = CMD_NONE;
        cmd.status = ST_OK;
        cmd.wdata  = item.data_byte;

        case (item.mode)
            MODE_PUSH:
            begin
                if (dropping_reg)
                begin
                    cmd.status = ST_DROP;
                    if (item.last_byte)
                    begin
                        dropping_next = 1'b0;
                    end
                end
                else if (wr_off_reg == '0 && count_reg == CNT_W'(SLOTS))
                begin
                    // queue full at packet start: drop the whole packet
                    cmd.status    = ST_DROP;
                    dropping_next = !item.last_byte;
                end
                else
                begin
                    if (wr_off_reg < OFF_W'(MAX_LEN))
                    begin
                        cmd.kind     = CMD_WRITE;
                        cmd.addr     = ADDR_W'(tail_reg) * ADDR_W'(MAX_LEN)
                                       + ADDR_W'(wr_off_reg);
                        wr_off_after = wr_off_reg + OFF_W'(1);
                    end
                    else
                    begin
                        cmd.status = ST_TRUNC;
                    end
                    wr_off_next = wr_off_after;
                    if (item.last_byte)
                    begin
                        commit      = 1'b1;
                        tail_next   = (tail_reg == IDX_W'(SLOTS - 1)) ? '0
                                                                     : tail_reg + IDX_W'(1);
                        count_next  = count_reg + CNT_W'(1);
                        wr_off_next = '0;
                    end
                end
            end
            MODE_POP:
            begin
                if (count_reg == '0)
                begin
                    cmd.status = ST_EMPTY;
                end
                else
                begin
                    cmd.kind   = CMD_READ;
                    cmd.addr   = ADDR_W'(head_reg) * ADDR_W'(MAX_LEN) + ADDR_W'(rd_off_reg);
                    cmd.length = head_len;
                    cmd.stamp  = stamp_reg[head_reg];
                    if (rd_off_inc >= CMP_W'(head_len))
                    begin
                        cmd.last    = 1'b1;
                        rd_off_next = '0;
                        head_next   = (head_reg == IDX_W'(SLOTS - 1)) ? '0
                                                                     : head_reg + IDX_W'(1);
                        count_next  = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        rd_off_next = rd_off_reg + OFF_W'(1);
                    end
                end
            end
            MODE_CLEAR:
            begin
                head_next     = '0;
                tail_next     = '0;
                count_next    = '0;
                wr_off_next   = '0;
                rd_off_next   = '0;
                dropping_next = 1'b0;
            end
            default:
            begin
                cmd.status = ST_OK;
            end
        endcase

        cmd.count = QCNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            wr_off_reg   <= '0;
            rd_off_reg   <= '0;
            dropping_reg <= 1'b0;
        end
        else if (accept)
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            wr_off_reg   <= wr_off_next;
            rd_off_reg   <= rd_off_next;
            dropping_reg <= dropping_next;
        end
    end

    // slot headers, written when a packet commits
    always_ff @(posedge clk)
    begin
        if (accept && commit)
        begin
            length_reg[tail_reg] <= LEN_W'(wr_off_after);
            stamp_reg[tail_reg]  <= item.stamp;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS) && wr_off_reg <= OFF_W'(MAX_LEN))
        else $error("queue count or write offset out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> wr_off_reg == '0)
        else $error("packet bytes stored while dropping");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.mode == MODE_POP && count_reg == '0
        |=> $stable(head_reg) && $stable(count_reg) && $stable(rd_off_reg))
        else $error("pop of empty queue changed state");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && cmd.kind == CMD_READ && cmd.last |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("slot not freed after last popped byte");
`endif

endmodule

@@ hdl/prq_cmd_queue.sv @@
// prq_cmd_queue: short command queue between front and back end.
// Uses prq_pkg for the command record and depth.
`timescale 1ns / 1ps

module prq_cmd_queue
    import prq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W_L = $clog2(QUEUE_DEPTH + 1);

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [QCNT_W_L-1:0] fill_reg;
    logic                push;
    logic                pop;

    assign in_ready  = fill_reg != QCNT_W_L'(QUEUE_DEPTH);
    assign out_valid = fill_reg != '0;
    assign out_cmd   = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // pointers wrap naturally, depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + QCNT_W_L'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - QCNT_W_L'(1);
            end
        end
    end

endmodule

@@ hdl/prq_back.sv @@
// prq_back: runs commands against the packet byte memory and holds the
// result register. Uses prq_pkg and prq_ram.
`timescale 1ns / 1ps

module prq_back
    import prq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic              s1_valid_reg;
    cmd_t              s1_cmd_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              s1_move;
    logic              issue;
    logic [BYTE_W-1:0] rdata;

    assign s1_move   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign cmd_ready = !s1_valid_reg || s1_move;
    assign issue     = cmd_valid && cmd_ready;

    // read data stays put while the stage stalls, since no access is issued
    prq_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BYTES_DEPTH)
    ) u_bytes (
        .clk   (clk),
        .en    (issue && cmd.kind != CMD_NONE),
        .we    (cmd.kind == CMD_WRITE),
        .addr  (cmd.addr),
        .wdata (cmd.wdata),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_cmd_reg <= cmd;
        end
        if (s1_move)
        begin
            out_res_reg.status      <= s1_cmd_reg.status;
            out_res_reg.out_byte    <= (s1_cmd_reg.kind == CMD_READ) ? rdata : '0;
            out_res_reg.out_last    <= s1_cmd_reg.last;
            out_res_reg.out_length  <= s1_cmd_reg.length;
            out_res_reg.out_stamp   <= s1_cmd_reg.stamp;
            out_res_reg.queue_count <= s1_cmd_reg.count;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_move |=> s1_valid_reg && $stable(rdata))
        else $error("read data lost while result stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("result dropped between stages");

    assert property (@(posedge clk) disable iff (!rst_n)
        issue && cmd.kind == CMD_WRITE |-> cmd.status == ST_OK && !cmd.last)
        else $error("byte write with non-ok status");
`endif

endmodule
